// ----- rtl/bssl_pkg.sv -----
// Shared types and constants for the box screen-size test.
// No dependencies.
`timescale 1ns / 1ps
package bssl_pkg;

  localparam int CoordW  = 32;             // input Q16.16 coordinate
  localparam int PointW  = 34;             // point coordinate, holds 2*max_z - min_z
  localparam int ProdW   = 66;             // matrix entry times point coordinate
  localparam int SumW    = 68;             // sum of one row
  localparam int ClipW   = 52;             // clip coordinate, Q36.16
  localparam int NumW    = ClipW + 1;      // c + w
  localparam int DenW    = ClipW + 1;      // 2 * w
  localparam int ProdNW  = NumW + 16;      // |c + w| * viewport
  localparam int ThrW    = 48;
  localparam int SqOutW  = 44;

  typedef logic signed [ClipW-1:0] clip_t;

  typedef struct packed {
    clip_t x;
    clip_t y;
    clip_t w;
  } clip_pt_t;

  typedef struct packed {
    clip_pt_t [3:0]  pt;
    logic [ThrW-1:0] thr;
  } proj_t;

  typedef struct packed {
    logic              renderable;
    logic [SqOutW-1:0] max_sq;
    logic              behind;
  } res_t;

  typedef struct packed {
    logic [63:0] x_lo;
    logic [63:0] x_hi;
    logic [63:0] y_lo;
    logic [63:0] y_hi;
    logic [63:0] w_lo;
    logic [63:0] w_hi;
  } mat_t;

  typedef enum logic [2:0] {
    REG_ROW_X_LO, REG_ROW_X_HI, REG_ROW_Y_LO, REG_ROW_Y_HI,
    REG_ROW_W_LO, REG_ROW_W_HI, REG_VP_W, REG_VP_H
  } reg_idx_t;

endpackage

// ----- rtl/bssl_fifo.sv -----
// Small register FIFO used as the inter-stage queue and the result buffer.
// Depends on nothing; DEPTH must be a power of two.
`timescale 1ns / 1ps
module bssl_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);
  localparam int AW = $clog2(DEPTH);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [AW:0]   cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= din;
  end

  assign dout  = mem_r[rd_ptr_r];
  assign empty = (cnt_r == '0);
endmodule

// ----- rtl/bssl_front.sv -----
// Front end: registers a box, forms its four points and projects them.
// Depends on bssl_pkg. Two register stages, never stalls.
`timescale 1ns / 1ps
module bssl_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        take,
  input  logic signed [31:0]          min_x,
  input  logic signed [31:0]          min_y,
  input  logic signed [31:0]          min_z,
  input  logic signed [31:0]          max_x,
  input  logic signed [31:0]          max_y,
  input  logic signed [31:0]          max_z,
  input  logic [47:0]                 thr,
  input  bssl_pkg::mat_t              mat,
  output logic                        push,
  output bssl_pkg::proj_t             dout
);
  import bssl_pkg::*;

  logic                     va_r, vb_r;
  logic signed [PointW-1:0] mn_r [3];
  logic signed [PointW-1:0] mx_r [3];
  logic signed [PointW-1:0] z3_r;
  logic [ThrW-1:0]          thra_r, thrb_r;
  logic signed [PointW-1:0] p [4][3];
  logic signed [31:0]       m [3][4];
  logic signed [ProdW-1:0]  prod_r [4][3][3];
  logic signed [SumW-1:0]   s [4][3];
  clip_t                    c [4][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= take;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    mn_r[0] <= PointW'(min_x);
    mn_r[1] <= PointW'(min_y);
    mn_r[2] <= PointW'(min_z);
    mx_r[0] <= PointW'(max_x);
    mx_r[1] <= PointW'(max_y);
    mx_r[2] <= PointW'(max_z);
    z3_r    <= (PointW'(max_z) <<< 1) - PointW'(min_z);
    thra_r  <= thr;
    thrb_r  <= thra_r;
  end

  always_comb begin
    m[0][0] = mat.x_lo[31:0];  m[0][1] = mat.x_lo[63:32];
    m[0][2] = mat.x_hi[31:0];  m[0][3] = mat.x_hi[63:32];
    m[1][0] = mat.y_lo[31:0];  m[1][1] = mat.y_lo[63:32];
    m[1][2] = mat.y_hi[31:0];  m[1][3] = mat.y_hi[63:32];
    m[2][0] = mat.w_lo[31:0];  m[2][1] = mat.w_lo[63:32];
    m[2][2] = mat.w_hi[31:0];  m[2][3] = mat.w_hi[63:32];
    // min, max, max with min z, max with z mirrored past max
    p[0][0] = mn_r[0]; p[0][1] = mn_r[1]; p[0][2] = mn_r[2];
    p[1][0] = mx_r[0]; p[1][1] = mx_r[1]; p[1][2] = mx_r[2];
    p[2][0] = mx_r[0]; p[2][1] = mx_r[1]; p[2][2] = mn_r[2];
    p[3][0] = mx_r[0]; p[3][1] = mx_r[1]; p[3][2] = z3_r;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++)
      for (int r = 0; r < 3; r++)
        for (int k = 0; k < 3; k++)
          prod_r[i][r][k] <= ProdW'(p[i][k]) * ProdW'(m[r][k]);
  end

  // Exact row sum, one floor at the end; w component of the point is 1.0.
  always_comb begin
    for (int i = 0; i < 4; i++)
      for (int r = 0; r < 3; r++) begin
        s[i][r] = SumW'(prod_r[i][r][0]) + SumW'(prod_r[i][r][1])
                + SumW'(prod_r[i][r][2]) + (SumW'(m[r][3]) <<< 16);
        c[i][r] = ClipW'(s[i][r] >>> 16);
      end
    for (int i = 0; i < 4; i++) begin
      dout.pt[i].x = c[i][0];
      dout.pt[i].y = c[i][1];
      dout.pt[i].w = c[i][2];
    end
    dout.thr = thrb_r;
  end

  assign push = vb_r;
endmodule

// ----- rtl/bssl_div.sv -----
// One window-coordinate lane: trunc((c+w)*vp/(2w)), saturated.
// Depends on bssl_pkg. Restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module bssl_div #(
  parameter int LIM_BITS = 20
) (
  input  logic                         clk,
  input  logic signed [bssl_pkg::NumW-1:0]  t,
  input  logic signed [bssl_pkg::ClipW-1:0] w,
  input  logic [15:0]                  vp,
  output logic signed [LIM_BITS+1:0]   win
);
  import bssl_pkg::*;

  localparam int NS = LIM_BITS + 1;
  localparam int RW = ProdNW + LIM_BITS + 2;
  localparam logic [LIM_BITS:0] LIM = (LIM_BITS+1)'(1) << LIM_BITS;

  logic [RW-1:0]       rem_r [NS+1];
  logic [DenW-1:0]     d_r   [NS+1];
  logic [LIM_BITS:0]   q_r   [NS+1];
  logic                neg_r [NS+1];
  logic                ok_r  [NS+1];
  logic                sat_r [NS+1];
  logic [NumW-1:0]     mag;
  logic [LIM_BITS:0]   qc;
  logic signed [LIM_BITS+1:0] win_r;

  assign mag = t[NumW-1] ? NumW'(-t) : NumW'(t);

  always_ff @(posedge clk) begin
    rem_r[0] <= RW'(ProdNW'(mag) * ProdNW'(vp));
    d_r[0]   <= {w, 1'b0};
    q_r[0]   <= '0;
    neg_r[0] <= t[NumW-1];
    ok_r[0]  <= !w[ClipW-1] && (w != '0);
    sat_r[0] <= 1'b0;
  end

  for (genvar k = 1; k <= NS; k++) begin : g_stage
    localparam int B = NS - k;
    logic [RW-1:0] dsh;
    logic          ge, ovf;
    assign dsh = RW'(d_r[k-1]) << B;
    assign ge  = rem_r[k-1] >= dsh;
    assign ovf = (k == 1) ? (rem_r[k-1] >= (dsh << 1)) : 1'b0;
    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? rem_r[k-1] - dsh : rem_r[k-1];
      q_r[k]   <= {q_r[k-1][LIM_BITS-1:0], ge};
      d_r[k]   <= d_r[k-1];
      neg_r[k] <= neg_r[k-1];
      ok_r[k]  <= ok_r[k-1];
      sat_r[k] <= sat_r[k-1] | ovf;
    end
  end

  assign qc = (sat_r[NS] || q_r[NS] > LIM) ? LIM : q_r[NS];

  always_ff @(posedge clk) begin
    if (!ok_r[NS])      win_r <= '0;
    else if (neg_r[NS]) win_r <= -$signed({1'b0, qc});
    else                win_r <= $signed({1'b0, qc});
  end

  assign win = win_r;
endmodule

// ----- rtl/bssl_back.sv -----
// Back end: window mapping of four points, diagonals and the size compare.
// Depends on bssl_pkg and bssl_div. Fully pipelined, never stalls.
`timescale 1ns / 1ps
module bssl_back #(
  parameter int LIM_BITS = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  bssl_pkg::proj_t   din,
  input  logic [15:0]       vp_w,
  input  logic [15:0]       vp_h,
  output logic              push,
  output bssl_pkg::res_t    dout
);
  import bssl_pkg::*;

  localparam int LD = LIM_BITS + 3;      // lane latency
  localparam int DW = LIM_BITS + 3;      // diagonal component
  localparam int SW = 2 * DW;

  logic signed [LIM_BITS+1:0] win [4][2];
  logic                 v_r  [LD];
  logic                 bh_r [LD];
  logic [ThrW-1:0]      th_r [LD];
  logic                 behind_in;
  logic signed [DW-1:0] dl [4];
  logic signed [SW-1:0] sq_r [4];
  logic                 sv_r, sb_r;
  logic [ThrW-1:0]      st_r;
  logic [63:0]          s0, s1, best, best_sh;

  for (genvar i = 0; i < 4; i++) begin : g_pt
    for (genvar a = 0; a < 2; a++) begin : g_ax
      logic signed [NumW-1:0] t;
      assign t = (a == 0) ? NumW'(din.pt[i].x) + NumW'(din.pt[i].w)
                          : NumW'(din.pt[i].y) + NumW'(din.pt[i].w);
      bssl_div #(.LIM_BITS(LIM_BITS)) u_lane (
        .clk (clk),
        .t   (t),
        .w   (din.pt[i].w),
        .vp  ((a == 0) ? vp_w : vp_h),
        .win (win[i][a])
      );
    end
  end

  always_comb begin
    behind_in = 1'b0;
    for (int i = 0; i < 4; i++)
      if (din.pt[i].w[ClipW-1] || din.pt[i].w == '0) behind_in = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LD; k++) v_r[k] <= 1'b0;
      sv_r <= 1'b0;
    end else begin
      v_r[0] <= take;
      for (int k = 1; k < LD; k++) v_r[k] <= v_r[k-1];
      sv_r <= v_r[LD-1];
    end
  end

  always_ff @(posedge clk) begin
    bh_r[0] <= behind_in;
    th_r[0] <= din.thr;
    for (int k = 1; k < LD; k++) begin
      bh_r[k] <= bh_r[k-1];
      th_r[k] <= th_r[k-1];
    end
    sb_r <= bh_r[LD-1];
    st_r <= th_r[LD-1];
  end

  // diagonals P1-P0 and P3-P2
  always_comb begin
    dl[0] = DW'(win[1][0]) - DW'(win[0][0]);
    dl[1] = DW'(win[1][1]) - DW'(win[0][1]);
    dl[2] = DW'(win[3][0]) - DW'(win[2][0]);
    dl[3] = DW'(win[3][1]) - DW'(win[2][1]);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) sq_r[k] <= SW'(dl[k]) * SW'(dl[k]);
  end

  always_comb begin
    s0      = 64'(sq_r[0]) + 64'(sq_r[1]);
    s1      = 64'(sq_r[2]) + 64'(sq_r[3]);
    best    = (s0 > s1) ? s0 : s1;
    best_sh = best << 16;
    dout.renderable = !sb_r && (best_sh < 64'(st_r));
    dout.max_sq     = best[SqOutW-1:0];
    dout.behind     = sb_r;
  end

  assign push = sv_r;
endmodule

// ----- rtl/box_screen_size_lod_test.sv -----
// Screen-size LOD test. Throughput one box per clock unless in_stall or out_stall holds the flow;
// depth is set by the restoring dividers, one bit per stage.
// Reset (rst_n low, synchronous) empties both queues and loads the default
// matrix (identity rows) and a 1024 x 768 viewport.
`timescale 1ns / 1ps
module box_screen_size_lod_test #(
  parameter int COORD_LIMIT_BITS = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_min_x,
  input  logic signed [31:0] in_min_y,
  input  logic signed [31:0] in_min_z,
  input  logic signed [31:0] in_max_x,
  input  logic signed [31:0] in_max_y,
  input  logic signed [31:0] in_max_z,
  input  logic [47:0]        in_size_threshold,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_renderable,
  output logic [43:0]        out_max_sq_diagonal,
  output logic               out_behind_eye,
  // configuration port, 64-bit registers at 8-byte spacing
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);
  import bssl_pkg::*;

  // Front: 2 stages then the projection queue. Back: lanes plus square stage.
  localparam int QD = 4;
  localparam int BL = COORD_LIMIT_BITS + 4;
  localparam int OD = 1 << $clog2(BL + 2);

  mat_t        mat_r;
  logic [15:0] vpw_r, vph_r;
  logic        wr;
  reg_idx_t    idx;

  logic        take, q_push, q_pop, q_empty, b_push, o_empty, o_take;
  proj_t       q_din, q_dout;
  res_t        b_dout, o_dout;
  logic [$clog2(QD+1)-1:0] qcnt_r, qcnt_nxt;
  logic [$clog2(OD+1)-1:0] ocnt_r, ocnt_nxt;

  // ---- configuration registers ----
  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r.x_lo <= 64'd65536;
      mat_r.x_hi <= '0;
      mat_r.y_lo <= 64'd65536 << 32;
      mat_r.y_hi <= '0;
      mat_r.w_lo <= '0;
      mat_r.w_hi <= 64'd65536 << 32;
      vpw_r      <= 16'd1024;
      vph_r      <= 16'd768;
    end else if (wr) begin
      case (idx)
        REG_ROW_X_LO: mat_r.x_lo <= pwdata;
        REG_ROW_X_HI: mat_r.x_hi <= pwdata;
        REG_ROW_Y_LO: mat_r.y_lo <= pwdata;
        REG_ROW_Y_HI: mat_r.y_hi <= pwdata;
        REG_ROW_W_LO: mat_r.w_lo <= pwdata;
        REG_ROW_W_HI: mat_r.w_hi <= pwdata;
        REG_VP_W:     vpw_r      <= pwdata[15:0];
        REG_VP_H:     vph_r      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ROW_X_LO: prdata = mat_r.x_lo;
      REG_ROW_X_HI: prdata = mat_r.x_hi;
      REG_ROW_Y_LO: prdata = mat_r.y_lo;
      REG_ROW_Y_HI: prdata = mat_r.y_hi;
      REG_ROW_W_LO: prdata = mat_r.w_lo;
      REG_ROW_W_HI: prdata = mat_r.w_hi;
      REG_VP_W:     prdata = 64'(vpw_r);
      REG_VP_H:     prdata = 64'(vph_r);
      default:      prdata = '0;
    endcase
  end

  // ---- credits ----
  // qcnt: boxes taken but not yet handed to the back end (front stages + queue).
  // ocnt: boxes in the back end or waiting in the result buffer.
  // Neither pipeline stalls; the credits keep both queues from overflowing.
  assign in_stall = (qcnt_r == ($clog2(QD+1))'(QD));
  assign take     = in_valid & ~in_stall;
  assign q_pop    = ~q_empty && (ocnt_r < ($clog2(OD+1))'(OD));
  assign o_take   = out_valid & ~out_stall;

  always_comb begin
    qcnt_nxt = qcnt_r;
    if (take && !q_pop) qcnt_nxt = qcnt_r + 1'b1;
    if (!take && q_pop) qcnt_nxt = qcnt_r - 1'b1;
    ocnt_nxt = ocnt_r;
    if (q_pop && !o_take) ocnt_nxt = ocnt_r + 1'b1;
    if (!q_pop && o_take) ocnt_nxt = ocnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qcnt_r <= '0;
      ocnt_r <= '0;
    end else begin
      qcnt_r <= qcnt_nxt;
      ocnt_r <= ocnt_nxt;
    end
  end

  // ---- front: points and clip coordinates ----
  bssl_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .min_x (in_min_x),
    .min_y (in_min_y),
    .min_z (in_min_z),
    .max_x (in_max_x),
    .max_y (in_max_y),
    .max_z (in_max_z),
    .thr   (in_size_threshold),
    .mat   (mat_r),
    .push  (q_push),
    .dout  (q_din)
  );

  bssl_fifo #(.W($bits(proj_t)), .DEPTH(QD)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  // ---- back: window mapping and size test ----
  bssl_back #(.LIM_BITS(COORD_LIMIT_BITS)) u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (q_pop),
    .din   (q_dout),
    .vp_w  (vpw_r),
    .vp_h  (vph_r),
    .push  (b_push),
    .dout  (b_dout)
  );

  // result buffer decouples the output transfer from the back pipeline
  bssl_fifo #(.W($bits(res_t)), .DEPTH(OD)) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (b_push),
    .din   (b_dout),
    .pop   (o_take),
    .dout  (o_dout),
    .empty (o_empty)
  );

  assign out_valid           = ~o_empty;
  assign out_renderable      = o_dout.renderable;
  assign out_max_sq_diagonal = o_dout.max_sq;
  assign out_behind_eye      = o_dout.behind;
endmodule

// ----- bench/box_screen_size_lod_test_tb.sv -----
// Self-checking bench for box_screen_size_lod_test: directed table, then random boxes
// under several matrix/viewport settings and idle/stall mixes. Depends on bssl_pkg and the RTL.
`timescale 1ns / 1ps
module box_screen_size_lod_test_tb;
  import bssl_pkg::*;

  localparam int LIM_BITS   = 20;
  localparam int HOLD_LEN   = 400;    // long receiver hold-off, cycles
  localparam int WDOG_LIMIT = 6000;   // cycles with no transfer before giving up
  localparam int DRAIN_WAIT = 40;     // a bit over the pipeline depth

  typedef struct {
    logic signed [31:0] mn_x, mn_y, mn_z, mx_x, mx_y, mx_z;
    logic [47:0]        thr;
  } box_t;

  // One directed row: a box, and optionally a result typed in by hand.
  typedef struct {
    box_t b;
    bit   fixed;
    res_t want;
  } row_t;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic signed [31:0] in_min_x = 0, in_min_y = 0, in_min_z = 0;
  logic signed [31:0] in_max_x = 0, in_max_y = 0, in_max_z = 0;
  logic [47:0]        in_size_threshold = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic               out_renderable;
  logic [43:0]        out_max_sq_diagonal;
  logic               out_behind_eye;
  logic               psel = 0, penable = 0, pwrite = 0;
  logic [5:0]         paddr = 0;
  logic [63:0]        pwdata = 0;
  logic [63:0]        prdata;
  logic               pready;

  box_screen_size_lod_test #(.COORD_LIMIT_BITS(LIM_BITS)) uut (.*);

  always #5 clk = ~clk;

  // Shadow of the register file, kept in step with every write.
  mat_t        mat_q;
  logic [15:0] vp_w_q, vp_h_q;

  res_t  want_q[$];      // expected results, oldest first
  bit    fixed_q[$];     // entry came from a hand-typed row
  int    n_err = 0;
  int    n_in = 0, n_out = 0, n_behind = 0, n_render = 0;
  int    idle_pct = 0, stall_pct = 0;
  bit    hold_on = 0;
  bit    cfg_busy = 0;
  // next_fixed / next_want: set by the driver for a hand-checked row
  bit    next_fixed = 0;
  res_t  next_want;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  // Row dot product with (x, y, z, 1.0), exact, then floor to Q64.16.
  function automatic logic signed [79:0] clip_coord(logic [63:0] lo, logic [63:0] hi,
      logic signed [33:0] px, logic signed [33:0] py, logic signed [33:0] pz);
    logic signed [79:0] acc;
    acc = $signed(lo[31:0]) * px + $signed(lo[63:32]) * py
        + $signed(hi[31:0]) * pz + $signed(hi[63:32]) * 80'sd65536;
    return acc >>> 16;
  endfunction

  // trunc((c + w) * vp / 2w), magnitude saturated to 2^LIM_BITS. Needs w > 0.
  function automatic logic signed [63:0] window_coord(logic signed [79:0] c,
      logic signed [79:0] w, logic [15:0] vp);
    logic signed [79:0] t;
    logic [127:0]       mag, num, den, q;
    t   = c + w;
    mag = t < 0 ? -t : t;
    num = mag * vp;
    den = w * 2;
    q   = num / den;
    if (q > (128'd1 << LIM_BITS)) q = 128'd1 << LIM_BITS;
    return t < 0 ? -$signed(q[63:0]) : $signed(q[63:0]);
  endfunction

  function automatic res_t screen_size(box_t b);
    logic signed [33:0] px[4], py[4], pz[4];
    logic signed [79:0] cx, cy, cw;
    logic signed [63:0] wx[4], wy[4], dx0, dy0, dx1, dy1;
    logic [63:0]        s0, s1, best;
    bit                 behind;
    res_t               r;
    behind = 0;
    px[0] = b.mn_x;  py[0] = b.mn_y;  pz[0] = b.mn_z;
    for (int i = 1; i < 4; i++) begin
      px[i] = b.mx_x;
      py[i] = b.mx_y;
    end
    pz[1] = b.mx_z;
    pz[2] = b.mn_z;
    pz[3] = 34'(2 * 34'(b.mx_z)) - 34'(b.mn_z);   // exact in 34 bits
    for (int i = 0; i < 4; i++) begin
      cx = clip_coord(mat_q.x_lo, mat_q.x_hi, px[i], py[i], pz[i]);
      cy = clip_coord(mat_q.y_lo, mat_q.y_hi, px[i], py[i], pz[i]);
      cw = clip_coord(mat_q.w_lo, mat_q.w_hi, px[i], py[i], pz[i]);
      if (cw <= 0) begin
        behind = 1;
        wx[i] = 0;
        wy[i] = 0;
      end else begin
        wx[i] = window_coord(cx, cw, vp_w_q);
        wy[i] = window_coord(cy, cw, vp_h_q);
      end
    end
    dx0 = wx[1] - wx[0];  dy0 = wy[1] - wy[0];
    dx1 = wx[3] - wx[2];  dy1 = wy[3] - wy[2];
    s0 = dx0 * dx0 + dy0 * dy0;
    s1 = dx1 * dx1 + dy1 * dy1;
    best = s0 > s1 ? s0 : s1;
    r.renderable = !behind && ((best << 16) < {16'd0, b.thr});
    r.max_sq     = best[43:0];
    r.behind     = behind;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Transfer detection: handshakes are sampled at the falling edge, where all
  // posedge updates have settled, and acted on at the following rising edge.
  // ---------------------------------------------------------------------------
  bit   in_fire, out_fire;
  box_t in_seen;
  res_t out_seen;

  always @(negedge clk) begin
    in_fire  = rst_n && in_valid && !in_stall;
    out_fire = rst_n && out_valid && !out_stall;
    in_seen  = '{in_min_x, in_min_y, in_min_z, in_max_x, in_max_y, in_max_z,
                 in_size_threshold};
    out_seen = '{out_renderable, out_max_sq_diagonal, out_behind_eye};
  end

  always @(posedge clk) begin
    res_t w;
    if (in_fire) begin
      w = screen_size(in_seen);
      if (next_fixed && w != next_want) begin
        $error("hand-typed row disagrees with predictor: %p vs %p", next_want, w);
        n_err++;
      end
      want_q.push_back(next_fixed ? next_want : w);
      n_in++;
    end
    if (out_fire) begin
      if (want_q.size() == 0) begin
        $error("result transfer with nothing expected: %p", out_seen);
        n_err++;
      end else begin
        w = want_q.pop_front();
        if (out_seen.renderable !== w.renderable) begin
          $error("renderable: expected %0d, got %0d", w.renderable, out_seen.renderable);
          n_err++;
        end
        if (out_seen.max_sq !== w.max_sq) begin
          $error("max_sq_diagonal: expected %0d, got %0d", w.max_sq, out_seen.max_sq);
          n_err++;
        end
        if (out_seen.behind !== w.behind) begin
          $error("behind_eye: expected %0d, got %0d", w.behind, out_seen.behind);
          n_err++;
        end
        n_out++;
        n_behind += w.behind;
        n_render += w.renderable;
      end
    end
  end

  // Receiver: random stalls at the current rate, or a solid hold-off.
  always @(posedge clk)
    out_stall <= hold_on || ($urandom_range(99) < stall_pct);

  // Long hold-off, timed here so the sender keeps pushing meanwhile.
  bit hold_req = 0;
  always begin
    wait (hold_req);
    hold_on = 1;
    repeat (HOLD_LEN) @(posedge clk);
    hold_on  = 0;
    hold_req = 0;
  end

  // Watchdog: any transfer (or a register write) resets the count.
  int quiet = 0;
  always @(posedge clk) begin
    if (in_fire || out_fire || cfg_busy || !rst_n)
      quiet <= 0;
    else if (quiet >= WDOG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d results outstanding",
               WDOG_LIMIT, want_q.size());
      $display("RESULT: ERROR");
      $finish;
    end else
      quiet <= quiet + 1;
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  task automatic reg_write(reg_idx_t idx, logic [63:0] val);
    cfg_busy = 1;
    psel    <= 1;
    penable <= 0;
    pwrite  <= 1;
    paddr   <= 6'(idx) << 3;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);         // write lands here, pready is tied high
    psel    <= 0;
    penable <= 0;
    pwrite  <= 0;
    case (idx)
      REG_ROW_X_LO: mat_q.x_lo = val;
      REG_ROW_X_HI: mat_q.x_hi = val;
      REG_ROW_Y_LO: mat_q.y_lo = val;
      REG_ROW_Y_HI: mat_q.y_hi = val;
      REG_ROW_W_LO: mat_q.w_lo = val;
      REG_ROW_W_HI: mat_q.w_hi = val;
      REG_VP_W:     vp_w_q     = val[15:0];
      REG_VP_H:     vp_h_q     = val[15:0];
      default: ;
    endcase
    cfg_busy = 0;
  endtask

  task automatic load_setting(logic [63:0] xl, logic [63:0] xh, logic [63:0] yl,
      logic [63:0] yh, logic [63:0] wl, logic [63:0] wh, logic [15:0] vw, logic [15:0] vh);
    reg_write(REG_ROW_X_LO, xl);
    reg_write(REG_ROW_X_HI, xh);
    reg_write(REG_ROW_Y_LO, yl);
    reg_write(REG_ROW_Y_HI, yh);
    reg_write(REG_ROW_W_LO, wl);
    reg_write(REG_ROW_W_HI, wh);
    reg_write(REG_VP_W, {48'd0, vw});
    reg_write(REG_VP_H, {48'd0, vh});
  endtask

  // Offer one box and hold it until it transfers; then idle cycle by cycle
  // at the current idle rate.
  task automatic send_box(box_t b);
    bit st;
    in_valid          <= 1;
    in_min_x          <= b.mn_x;
    in_min_y          <= b.mn_y;
    in_min_z          <= b.mn_z;
    in_max_x          <= b.mx_x;
    in_max_y          <= b.mx_y;
    in_max_z          <= b.mx_z;
    in_size_threshold <= b.thr;
    do begin
      @(negedge clk);
      st = in_stall;
      @(posedge clk);
    end while (st);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (want_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Q16.16 helpers for readable random values.
  function automatic logic signed [31:0] near_coord();
    return $signed($urandom_range(32'h000C_0000)) - 32'sh0006_0000;   // about +-6.0
  endfunction

  function automatic logic [63:0] near_pair();
    logic signed [31:0] a, b;
    a = $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;     // about +-2.0
    b = $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
    return {b, a};
  endfunction

  function automatic box_t random_box();
    box_t b;
    case ($urandom_range(9))
      0, 1: begin    // full-range bits everywhere
        b = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              48'({$urandom, $urandom})};
      end
      default: begin // sane boxes, sometimes inverted
        b.mn_x = near_coord();  b.mn_y = near_coord();  b.mn_z = near_coord();
        b.mx_x = near_coord();  b.mx_y = near_coord();  b.mx_z = near_coord();
        if ($urandom_range(3) != 0) begin
          if (b.mx_x < b.mn_x) {b.mx_x, b.mn_x} = {b.mn_x, b.mx_x};
          if (b.mx_y < b.mn_y) {b.mx_y, b.mn_y} = {b.mn_y, b.mx_y};
          if (b.mx_z < b.mn_z) {b.mx_z, b.mn_z} = {b.mn_z, b.mx_z};
        end
        // threshold near typical sizes so both outcomes show up
        b.thr = 48'({$urandom_range(32'h00FF_FFFF), 16'($urandom)}) >> $urandom_range(20);
      end
    endcase
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table, reset setting (identity x/y rows, w = 1.0, 1024 x 768)
  // ---------------------------------------------------------------------------
  localparam logic signed [31:0] ONE  = 32'sh0001_0000;
  localparam logic signed [31:0] MAXC = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MINC = 32'sh8000_0000;
  localparam logic [47:0]        THR_MAX = 48'hFFFF_FFFF_FFFF;

  row_t dir_rows[] = '{
    // degenerate box at the origin: every point maps to (512, 384), diagonal 0
    '{'{0, 0, 0, 0, 0, 0, 48'd1}, 1, '{1'b1, 44'd0, 1'b0}},
    '{'{0, 0, 0, 0, 0, 0, 48'd0}, 1, '{1'b0, 44'd0, 1'b0}},
    // NDC corner to corner: 1024^2 + 768^2
    '{'{-ONE, -ONE, 0, ONE, ONE, 0, 48'd0}, 1, '{1'b0, 44'd1638400, 1'b0}},
    '{'{-ONE, -ONE, 0, ONE, ONE, 0, THR_MAX}, 1, '{1'b1, 44'd1638400, 1'b0}},
    // extremes of every coordinate; window coords saturate
    '{'{MINC, MINC, MINC, MAXC, MAXC, MAXC, THR_MAX}, 0, '{0, 0, 0}},
    '{'{MAXC, MAXC, MAXC, MINC, MINC, MINC, THR_MAX}, 0, '{0, 0, 0}},
    '{'{MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, 48'd0}, 0, '{0, 0, 0}},
    '{'{MINC, MINC, MINC, MINC, MINC, MINC, 48'd1}, 0, '{0, 0, 0}},
    '{'{MINC, 0, MAXC, MAXC, 0, MINC, 48'h8000_0000_0000}, 0, '{0, 0, 0}},
    // inverted box
    '{'{ONE, ONE, ONE, -ONE, -ONE, -ONE, 48'h0019_0000_0000}, 0, '{0, 0, 0}},
    // threshold right at the diagonal (strict compare) and one above
    '{'{-ONE, -ONE, 0, ONE, ONE, 0, 48'h0019_0000_0000}, 0, '{0, 0, 0}},
    '{'{-ONE, -ONE, 0, ONE, ONE, 0, 48'h0019_0000_0001}, 0, '{0, 0, 0}},
    // small fractions, just off center
    '{'{32'sh0000_0001, -32'sh0000_0001, 0, 32'sh0000_8000, 32'sh0000_4000, ONE,
        48'h7FFF}, 0, '{0, 0, 0}}
  };

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  int n_phase = 0;

  task automatic random_phase(int count, int ip, int sp, bit with_hold);
    idle_pct  = ip;
    stall_pct = sp;
    for (int i = 0; i < count; i++) begin
      if (with_hold && i == count / 3) hold_req = 1;
      send_box(random_box());
    end
    drain();
    n_phase++;
  endtask

  initial begin
    mat_q  = '{64'd65536, 64'd0, 64'd65536 << 32, 64'd0, 64'd0, 64'd65536 << 32};
    vp_w_q = 16'd1024;
    vp_h_q = 16'd768;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      next_want  = dir_rows[i].want;
      next_fixed = dir_rows[i].fixed;
      send_box(dir_rows[i].b);
      in_valid <= 0;
      // wait for this one transfer to be logged before changing the flag
      @(posedge clk);
      next_fixed = 0;
    end
    drain();

    // reset setting, no idling on either side
    random_phase(140, 0, 0, 0);

    // perspective-style w row (w = -z + 2.0): points in front and behind the eye
    load_setting(64'd65536, 64'd0, 64'd65536 << 32, 64'd0,
                 64'd0, {32'h0002_0000, 32'hFFFF_0000}, 16'd1920, 16'd1080);
    random_phase(140, 80, 0, 0);

    // random small matrices; long hold-off so the pipeline backs up
    load_setting(near_pair(), near_pair(), near_pair(), near_pair(),
                 near_pair(), {32'h0001_0000 + $urandom_range(32'h0004_0000), 32'h0}
                 | (near_pair() & 64'hFFFF_FFFF),
                 16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1)));
    random_phase(140, 0, 80, 1);

    // smallest viewport, and full-range bits in every entry
    load_setting({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                 16'd1, 16'd1);
    random_phase(140, 36, 36, 0);

    // extreme entries in the x and y rows and the w offset, and the largest viewport
    load_setting({MAXC, MAXC}, {MINC, MAXC}, {MINC, MINC}, {MAXC, MINC},
                 {32'h0, 32'h0}, {MAXC, 32'h0}, 16'hFFFF, 16'hFFFF);
    random_phase(140, 36, 36, 0);

    // back to a random sane setting, mixed pressure and another hold-off
    load_setting(near_pair(), near_pair(), near_pair(), near_pair(),
                 64'd0, 64'h0001_0000_0000 | (near_pair() & 64'hFFFF_FFFF),
                 16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1)));
    random_phase(140, 36, 36, 1);

    $display("covered %0d boxes in %0d random phases plus a directed table;",
             n_in, n_phase);
    $display("%0d results checked, %0d behind the eye, %0d renderable",
             n_out, n_behind, n_render);
    if (n_err == 0 && want_q.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
